### hw/rtl/pfsa_pkg.sv
// Package for the page frame state allocator.
// Holds field widths, operation and frame type codes and the memory request type.
// No dependencies.
package pfsa_pkg;

  localparam int OP_W      = 3;
  localparam int FRAME_W   = 20;
  localparam int TYPE_W    = 3;
  localparam int OWNER_W   = 16;
  localparam int CNT_W     = 7;
  localparam int APB_ADDR_W = 2;
  localparam int APB_DATA_W = 32;

  localparam logic [OP_W-1:0] OP_SET_TYPE = 3'd0;
  localparam logic [OP_W-1:0] OP_MAP      = 3'd1;
  localparam logic [OP_W-1:0] OP_FIND     = 3'd2;
  localparam logic [OP_W-1:0] OP_CHECK    = 3'd3;
  localparam logic [OP_W-1:0] OP_ALLOC    = 3'd4;

  localparam logic [TYPE_W-1:0] FT_NOT_MAPPED = 3'd0;
  localparam logic [TYPE_W-1:0] FT_USABLE     = 3'd1;
  localparam logic [TYPE_W-1:0] FT_IN_USE     = 3'd2;
  localparam logic [TYPE_W-1:0] FT_LAST_CODE  = 3'd5;

  localparam logic [APB_ADDR_W-1:0] CFG_ADDR_OS_OWNER = 2'd0;

  typedef struct packed {
    logic               rd_en;
    logic [FRAME_W-1:0] rd_addr;
    logic               type_we;
    logic               owner_we;
    logic [FRAME_W-1:0] wr_addr;
    logic [TYPE_W-1:0]  wr_type;
    logic [OWNER_W-1:0] wr_owner;
  } mem_req_t;

endpackage

### hw/rtl/pfsa_in_if.sv
// Input channel of the page frame state allocator: one operation word.
// Depends on pfsa_pkg.
interface pfsa_in_if import pfsa_pkg::*;;
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [FRAME_W-1:0] frame;
  logic [TYPE_W-1:0]  frame_type;
  logic [OWNER_W-1:0] owner;
  logic [CNT_W-1:0]   count;

  modport source (output valid, op, frame, frame_type, owner, count, input ready);
  modport sink   (input valid, op, frame, frame_type, owner, count, output ready);
endinterface

### hw/rtl/pfsa_out_if.sv
// Result channel of the page frame state allocator: one result word.
// Depends on pfsa_pkg.
interface pfsa_out_if import pfsa_pkg::*;;
  logic               valid;
  logic               ready;
  logic [FRAME_W-1:0] result_frame;
  logic               ok;
  logic               last;

  modport source (output valid, result_frame, ok, last, input ready);
  modport sink   (input valid, result_frame, ok, last, output ready);
endinterface

### hw/rtl/pfsa_frame_mem.sv
// Frame state memories: type code and owner id per frame.
// One write port and one registered read port. Depends on pfsa_pkg.
module pfsa_frame_mem import pfsa_pkg::*; #(
  parameter int FRAMES = 65536
) (
  input  logic              clk,
  input  mem_req_t          req,
  output logic [TYPE_W-1:0] rd_type
);

  localparam int AW = (FRAMES > 1) ? $clog2(FRAMES) : 1;

  logic [TYPE_W-1:0]  type_mem  [FRAMES];
  logic [OWNER_W-1:0] owner_mem [FRAMES];
  logic [TYPE_W-1:0]  rd_type_r;

  always_ff @(posedge clk) begin
    if (req.type_we) begin
      type_mem[req.wr_addr[AW-1:0]] <= req.wr_type;
    end
    if (req.rd_en) begin
      rd_type_r <= type_mem[req.rd_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (req.owner_we) begin
      owner_mem[req.wr_addr[AW-1:0]] <= req.wr_owner;
    end
  end

  assign rd_type = rd_type_r;

endmodule

### hw/rtl/pfsa_cfg_regs.sv
// APB-style register port holding the owner id used by allocate.
// Depends on pfsa_pkg.
module pfsa_cfg_regs import pfsa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [OWNER_W-1:0]    os_owner
);

  logic [OWNER_W-1:0] os_owner_r;
  logic [OWNER_W-1:0] os_owner_nxt;
  logic               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr == CFG_ADDR_OS_OWNER);

  always_comb begin
    os_owner_nxt = os_owner_r;
    if (wr_en) begin
      os_owner_nxt = pwdata[OWNER_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      os_owner_r <= '0;
    end else begin
      os_owner_r <= os_owner_nxt;
    end
  end

  assign prdata   = (paddr == CFG_ADDR_OS_OWNER) ?
                    {{(APB_DATA_W-OWNER_W){1'b0}}, os_owner_r} : '0;
  assign os_owner = os_owner_r;

endmodule

### hw/rtl/pfsa_ctrl.sv
// Sequencer of the allocator: clearing pass, set and map writes, table scans,
// allocate write-back and the output register. Depends on pfsa_pkg and the channel interfaces.
module pfsa_ctrl import pfsa_pkg::*; #(
  parameter int FRAMES    = 65536,
  parameter int MAX_ALLOC = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  pfsa_in_if.sink            in_ch,
  pfsa_out_if.source         out_ch,
  input  logic [OWNER_W-1:0] os_owner,
  output mem_req_t           mem_req,
  input  logic [TYPE_W-1:0]  rd_type
);

  localparam int AW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam logic [AW-1:0]      LAST_ADDR   = AW'(FRAMES - 1);
  localparam logic [CNT_W-1:0]   ALLOC_CAP   = CNT_W'(MAX_ALLOC);
  localparam logic [FRAME_W:0]   FRAME_LIMIT = (FRAME_W + 1)'(FRAMES);

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_SCAN, ST_FLUSH} state_t;

  state_t             state_r, state_nxt;
  logic [AW-1:0]      clr_addr_r, clr_addr_nxt;
  logic [AW-1:0]      iss_addr_r, iss_addr_nxt;
  logic               iss_act_r, iss_act_nxt;
  logic               ev_valid_r, ev_valid_nxt;
  logic [AW-1:0]      ev_addr_r, ev_addr_nxt;
  logic               ev_last_r, ev_last_nxt;
  logic               alloc_r, alloc_nxt;
  logic               chk_r, chk_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               pend_valid_r, pend_valid_nxt;
  logic [AW-1:0]      pend_frame_r, pend_frame_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [FRAME_W-1:0] out_frame_r, out_frame_nxt;
  logic               out_ok_r, out_ok_nxt;
  logic               out_last_r, out_last_nxt;

  logic               slot_free;
  logic               accept;
  logic               frame_ok;
  logic               type_ok;
  logic               ev_usable;
  logic               stall;
  logic               adv;
  logic               take;
  logic [CNT_W-1:0]   cnt_inc;
  logic               push;
  logic [FRAME_W-1:0] push_frame;
  logic               push_ok;
  logic               push_last;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept    = in_ch.valid && in_ch.ready;
  assign frame_ok  = ({1'b0, in_ch.frame} < FRAME_LIMIT);
  assign type_ok   = (in_ch.frame_type <= FT_LAST_CODE);
  assign ev_usable = ev_valid_r && (rd_type == FT_USABLE);
  assign stall     = ev_usable && alloc_r && pend_valid_r && !slot_free;
  assign adv       = (state_r == ST_SCAN) && !stall;
  assign take      = adv && ev_usable;
  assign cnt_inc   = cnt_r + 1'b1;

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    iss_addr_nxt   = iss_addr_r;
    iss_act_nxt    = iss_act_r;
    ev_valid_nxt   = ev_valid_r;
    ev_addr_nxt    = ev_addr_r;
    ev_last_nxt    = ev_last_r;
    alloc_nxt      = alloc_r;
    chk_nxt        = chk_r;
    count_nxt      = count_r;
    cnt_nxt        = cnt_r;
    pend_valid_nxt = pend_valid_r;
    pend_frame_nxt = pend_frame_r;
    push           = 1'b0;
    push_frame     = '0;
    push_ok        = 1'b0;
    push_last      = 1'b0;
    mem_req        = '0;

    case (state_r)
      ST_CLEAR: begin
        mem_req.type_we  = 1'b1;
        mem_req.owner_we = 1'b1;
        mem_req.wr_addr  = FRAME_W'(clr_addr_r);
        mem_req.wr_type  = FT_NOT_MAPPED;
        mem_req.wr_owner = '0;
        clr_addr_nxt     = clr_addr_r + 1'b1;
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          alloc_nxt      = 1'b0;
          chk_nxt        = 1'b0;
          cnt_nxt        = '0;
          pend_valid_nxt = 1'b0;
          iss_addr_nxt   = '0;
          iss_act_nxt    = 1'b1;
          ev_valid_nxt   = 1'b0;
          state_nxt      = ST_FLUSH;
          case (in_ch.op)
            OP_SET_TYPE, OP_MAP: begin
              if (frame_ok && type_ok) begin
                mem_req.type_we  = 1'b1;
                mem_req.owner_we = (in_ch.op == OP_MAP);
                mem_req.wr_addr  = in_ch.frame;
                mem_req.wr_type  = in_ch.frame_type;
                mem_req.wr_owner = in_ch.owner;
                pend_valid_nxt   = 1'b1;
                pend_frame_nxt   = in_ch.frame[AW-1:0];
              end
            end
            OP_FIND: begin
              count_nxt = CNT_W'(1);
              state_nxt = ST_SCAN;
            end
            OP_CHECK: begin
              if (in_ch.count != '0) begin
                count_nxt = in_ch.count;
                chk_nxt   = 1'b1;
                state_nxt = ST_SCAN;
              end
            end
            OP_ALLOC: begin
              if (in_ch.count != '0) begin
                count_nxt = (in_ch.count > ALLOC_CAP) ? ALLOC_CAP : in_ch.count;
                alloc_nxt = 1'b1;
                state_nxt = ST_SCAN;
              end
            end
            default: begin
              state_nxt = ST_FLUSH;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (adv) begin
          mem_req.rd_en   = iss_act_r;
          mem_req.rd_addr = FRAME_W'(iss_addr_r);
          ev_valid_nxt    = iss_act_r;
          ev_addr_nxt     = iss_addr_r;
          ev_last_nxt     = (iss_addr_r == LAST_ADDR);
          iss_addr_nxt    = iss_addr_r + 1'b1;
          iss_act_nxt     = iss_act_r && (iss_addr_r != LAST_ADDR);
          if (take) begin
            cnt_nxt = cnt_inc;
            if (!chk_r) begin
              pend_valid_nxt = 1'b1;
              pend_frame_nxt = ev_addr_r;
            end
            if (alloc_r) begin
              mem_req.type_we  = 1'b1;
              mem_req.owner_we = 1'b1;
              mem_req.wr_addr  = FRAME_W'(ev_addr_r);
              mem_req.wr_type  = FT_IN_USE;
              mem_req.wr_owner = os_owner;
              if (pend_valid_r) begin
                push       = 1'b1;
                push_frame = FRAME_W'(pend_frame_r);
                push_ok    = 1'b1;
                push_last  = 1'b0;
              end
            end
          end
          if ((ev_valid_r && ev_last_r) || (take && (cnt_inc == count_r))) begin
            ev_valid_nxt = 1'b0;
            state_nxt    = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (slot_free) begin
          push       = 1'b1;
          push_last  = 1'b1;
          push_ok    = chk_r ? (cnt_r == count_r) : pend_valid_r;
          push_frame = (!chk_r && pend_valid_r) ? FRAME_W'(pend_frame_r) : '0;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = push || (out_valid_r && !out_ch.ready);
    out_frame_nxt = push ? push_frame : out_frame_r;
    out_ok_nxt    = push ? push_ok    : out_ok_r;
    out_last_nxt  = push ? push_last  : out_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_addr_r   <= '0;
      iss_act_r    <= 1'b0;
      ev_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
      alloc_r      <= 1'b0;
      chk_r        <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_addr_r   <= clr_addr_nxt;
      iss_act_r    <= iss_act_nxt;
      ev_valid_r   <= ev_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
      alloc_r      <= alloc_nxt;
      chk_r        <= chk_nxt;
    end
    iss_addr_r   <= iss_addr_nxt;
    ev_addr_r    <= ev_addr_nxt;
    ev_last_r    <= ev_last_nxt;
    count_r      <= count_nxt;
    cnt_r        <= cnt_nxt;
    pend_frame_r <= pend_frame_nxt;
    out_frame_r  <= out_frame_nxt;
    out_ok_r     <= out_ok_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_frame = out_frame_r;
  assign out_ch.ok           = out_ok_r;
  assign out_ch.last         = out_last_r;

  a_hold_read_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    stall |-> !mem_req.rd_en)
    else $error("table read issued while the evaluated entry is held");

  a_scan_below_target: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (cnt_r < count_r))
    else $error("scan continued after reaching its frame count");

  a_writeback_usable: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SCAN) && mem_req.type_we) |-> (ev_usable && alloc_r))
    else $error("scan wrote a frame that was not usable");

  a_push_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> slot_free)
    else $error("result overwrote a word not yet taken");

endmodule

### hw/rtl/page_frame_state_allocator.sv
// Top level of the page frame state allocator.
// Depends on pfsa_pkg, pfsa_in_if, pfsa_out_if, pfsa_frame_mem, pfsa_cfg_regs, pfsa_ctrl.
//
//   channel   direction  handshake           payload
//   in_ch     in         valid/ready         op, frame, frame_type, owner, count
//   out_ch    out        valid/ready         result_frame, ok, last
//   cfg (APB) in         psel/penable/pready os_owner at byte address 0
//
// After reset a clearing pass writes every frame entry before a word is taken.
// Set type and map words write the frame when taken; these and rejected words then deliver the result.
// Find, check and allocate read the type memory one frame a cycle from frame zero while the scan
// is not held, through the single read port of the type memory.
// A stalled result port holds the scan of allocate whenever another frame is found while the
// previous one still waits, and it holds the final word of every operation.
module page_frame_state_allocator import pfsa_pkg::*; #(
  parameter int FRAMES    = 65536,
  parameter int MAX_ALLOC = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  pfsa_in_if.sink               in_ch,
  pfsa_out_if.source            out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [OWNER_W-1:0] os_owner;
  mem_req_t           mem_req;
  logic [TYPE_W-1:0]  rd_type;

  pfsa_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .os_owner (os_owner)
  );

  pfsa_frame_mem #(
    .FRAMES (FRAMES)
  ) u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_type (rd_type)
  );

  pfsa_ctrl #(
    .FRAMES    (FRAMES),
    .MAX_ALLOC (MAX_ALLOC)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .os_owner (os_owner),
    .mem_req  (mem_req),
    .rd_type  (rd_type)
  );

endmodule
